// ----- rtl/core/suk_pkg.sv -----
`timescale 1ns / 1ps

package suk_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_BITS = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OUT_W    = 5;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_DUP  = 2'd1,
        ST_MISS = 2'd2,
        ST_FULL = 2'd3
    } t_status;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic                       ins;
        logic                       del;
        logic signed [KEY_BITS-1:0] key;
    } t_cell_ctl;

endpackage

// ----- rtl/core/sorted_unique_key_table.sv -----
`timescale 1ns / 1ps
// Sorted table of distinct signed keys held in a chain of compare/shift cells.
// An accepted item's result is loaded into the output register on the next clock edge.
// Throughput: one item per cycle while the output is not stalled; all cells compare in parallel, then shift.
// Reset (synchronous, active low) empties the table and clears the output valid.
// Key storage is not reset; only cells marked valid are ever compared.

module sorted_unique_key_table
    import suk_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_command,
    input  logic signed [31:0]  i_key,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_status,
    output logic [OUT_W-1:0]    o_position,
    output logic [OUT_W-1:0]    o_entry_count
);

    // Chain taps
    logic signed [KEY_BITS-1:0] w_key   [CAPACITY];
    logic [CAPACITY-1:0]        w_valid;
    logic [CAPACITY-1:0]        w_lt;
    logic [CAPACITY-1:0]        w_eq;
    logic [CAPACITY-1:0]        w_prev_lt;
    logic [CAPACITY-1:0]        w_first;

    t_cell_ctl                  w_ctl;
    logic                       w_accept;
    logic                       w_hit;
    logic                       w_full;
    logic [IDX_W-1:0]           w_place;
    logic [CNT_W-1:0]           w_rank;

    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           n_count;
    logic                       r_out_valid;
    logic                       n_out_valid;
    t_status                    r_status;
    t_status                    n_status;
    logic [CNT_W-1:0]           r_pos;
    logic [CNT_W-1:0]           n_pos;

    // Take a new item whenever the output register is free or drains this cycle.
    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    assign w_hit  = |w_eq;
    assign w_full = (r_count == CNT_W'(CAPACITY));

    // Cells below the search key form a prefix of ones; find where it ends.
    assign w_prev_lt = {w_lt[CAPACITY-2:0], 1'b1};
    assign w_first   = w_prev_lt & ~w_lt;

    always_comb begin
        w_place = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_first[i]) begin
                w_place = w_place | IDX_W'(i);
            end
        end
    end

    assign w_rank = CNT_W'(w_place) + CNT_W'(1);

    // Decode the command into the shift request and the result.
    always_comb begin
        w_ctl.key = i_key[KEY_BITS-1:0];
        w_ctl.ins = 1'b0;
        w_ctl.del = 1'b0;
        n_status  = ST_MISS;
        n_pos     = '0;
        case (t_cmd'(i_command))
            CMD_INSERT: begin
                if (w_hit) begin
                    n_status = ST_DUP;
                    n_pos    = w_rank;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctl.ins = w_accept;
                    n_status  = ST_DONE;
                    n_pos     = w_rank;
                end
            end
            CMD_DELETE: begin
                if (w_hit) begin
                    w_ctl.del = w_accept;
                    n_status  = ST_DONE;
                    n_pos     = w_rank;
                end
            end
            CMD_SEARCH: begin
                if (w_hit) begin
                    n_status = ST_DONE;
                    n_pos    = w_rank;
                end
            end
            default: begin
                n_status = ST_MISS;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_ctl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.del) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign n_out_valid = w_accept || (r_out_valid && i_stall);

    // The cell chain: each cell sees its lower neighbor for insert shifts
    // and its upper neighbor for delete shifts.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [KEY_BITS-1:0] w_pk;
        logic                       w_pv;
        logic signed [KEY_BITS-1:0] w_nk;
        logic                       w_nv;

        if (g == 0) begin : g_lo
            assign w_pk = '0;
            assign w_pv = 1'b0;
        end else begin : g_lo
            assign w_pk = w_key[g-1];
            assign w_pv = w_valid[g-1];
        end

        if (g == CAPACITY - 1) begin : g_hi
            assign w_nk = '0;
            assign w_nv = 1'b0;
        end else begin : g_hi
            assign w_nk = w_key[g+1];
            assign w_nv = w_valid[g+1];
        end

        suk_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_prev_lt    (w_prev_lt[g]),
            .i_prev_key   (w_pk),
            .i_prev_valid (w_pv),
            .i_next_key   (w_nk),
            .i_next_valid (w_nv),
            .o_key        (w_key[g]),
            .o_valid      (w_valid[g]),
            .o_lt         (w_lt[g]),
            .o_eq         (w_eq[g])
        );
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload: load on accept, hold while stalled.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_pos    <= n_pos;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_position    = OUT_W'(r_pos);
    assign o_entry_count = OUT_W'(r_count);

endmodule

// ----- rtl/core/suk_cell.sv -----
`timescale 1ns / 1ps

module suk_cell
    import suk_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cell_ctl                  i_ctl,
    input  logic                       i_prev_lt,
    input  logic signed [KEY_BITS-1:0] i_prev_key,
    input  logic                       i_prev_valid,
    input  logic signed [KEY_BITS-1:0] i_next_key,
    input  logic                       i_next_valid,
    output logic signed [KEY_BITS-1:0] o_key,
    output logic                       o_valid,
    output logic                       o_lt,
    output logic                       o_eq
);

    logic signed [KEY_BITS-1:0] r_key;
    logic                       r_valid;
    logic                       w_first;

    assign o_lt    = r_valid && (r_key < i_ctl.key);
    assign o_eq    = r_valid && (r_key == i_ctl.key);
    assign w_first = i_prev_lt && !o_lt;
    assign o_key   = r_key;
    assign o_valid = r_valid;

    // Cells below the insert/delete point hold; the rest shift by one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.ins && !o_lt) begin
            r_valid <= w_first ? 1'b1 : i_prev_valid;
        end else if (i_ctl.del && !o_lt) begin
            r_valid <= i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && !o_lt) begin
            r_key <= w_first ? i_ctl.key : i_prev_key;
        end else if (i_ctl.del && !o_lt) begin
            r_key <= i_next_key;
        end
    end

endmodule

// ----- bench/tb_sorted_unique_key_table.sv -----
`timescale 1ns / 1ps

module tb_sorted_unique_key_table;
    import suk_pkg::*;

    localparam int RANDOM_OPS = 730;
    localparam int POOL_SIZE  = 24;
    localparam int PRINT_CAP  = 40;

    typedef logic signed [KEY_BITS-1:0] table_key_t;

    typedef struct {
        t_cmd       cmd;
        table_key_t key;
    } table_op_t;

    typedef struct {
        t_status        status;
        logic [OUT_W-1:0] position;
        logic [OUT_W-1:0] count;
    } table_reply_t;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_valid       = 1'b0;
    logic [1:0]         i_command     = CMD_SEARCH;
    logic signed [31:0] i_key         = '0;
    logic               i_stall       = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [1:0]         o_status;
    logic [OUT_W-1:0]   o_position;
    logic [OUT_W-1:0]   o_entry_count;

    sorted_unique_key_table u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_key         (i_key),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_entry_count (o_entry_count)
    );

    // Shadow copy of the sorted table, ascending, first shadow_count slots valid.
    table_key_t   shadow_keys [CAPACITY];
    int           shadow_count = 0;

    table_op_t    ops_to_send [$];
    table_reply_t replies_due [$];
    table_reply_t reply_want;
    table_key_t   key_pool [POOL_SIZE];

    int total_ops     = 0;
    int ops_accepted  = 0;
    int replies_seen  = 0;
    int errors        = 0;
    int status_tally [4] = '{0, 0, 0, 0};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Split the run into quarters by accepted items: no idling, sender gaps,
    // receiver stalls, then both at a lighter rate.
    function automatic int pacing_phase();
        if (total_ops == 0) return 0;
        return (ops_accepted * 4) / total_ops;
    endfunction

    function automatic int send_gap_pct();
        case (pacing_phase())
            1:       return 80;
            3:       return 34;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct();
        case (pacing_phase())
            2:       return 80;
            3:       return 34;
            default: return 0;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (errors < PRINT_CAP) $display("[%0t] MISMATCH: %s", $realtime, msg);
        errors++;
    endtask

    task automatic queue_op(input t_cmd cmd, input table_key_t key);
        table_op_t op;
        op.cmd = cmd;
        op.key = key;
        ops_to_send.push_back(op);
        total_ops++;
    endtask

    // Apply one command to the shadow table and queue the reply it must produce.
    task automatic apply_table_op(input logic [1:0] cmd, input table_key_t key);
        int           slot;
        bit           hit;
        table_reply_t r;
        slot = 0;
        while (slot < shadow_count && shadow_keys[slot] < key) slot++;
        hit = (slot < shadow_count) && (shadow_keys[slot] == key);
        r.status   = ST_MISS;
        r.position = '0;
        case (t_cmd'(cmd))
            CMD_INSERT: begin
                // Duplicate wins over full.
                if (hit) begin
                    r.status   = ST_DUP;
                    r.position = OUT_W'(slot + 1);
                end else if (shadow_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = shadow_count; i > slot; i--)
                        shadow_keys[i] = shadow_keys[i-1];
                    shadow_keys[slot] = key;
                    shadow_count++;
                    r.status   = ST_DONE;
                    r.position = OUT_W'(slot + 1);
                end
            end
            CMD_DELETE: begin
                if (hit) begin
                    for (int i = slot; i + 1 < shadow_count; i++)
                        shadow_keys[i] = shadow_keys[i+1];
                    shadow_count--;
                    r.status   = ST_DONE;
                    r.position = OUT_W'(slot + 1);
                end
            end
            CMD_SEARCH: begin
                if (hit) begin
                    r.status   = ST_DONE;
                    r.position = OUT_W'(slot + 1);
                end
            end
            default: ;
        endcase
        r.count = OUT_W'(shadow_count);
        replies_due.push_back(r);
    endtask

    function automatic table_key_t pick_key();
        // Mostly keys from the pool so hits and duplicates are common.
        if ($urandom_range(99) < 85) return key_pool[$urandom_range(POOL_SIZE - 1)];
        return table_key_t'($urandom);
    endfunction

    // Driver: advance on acceptance, hold the item while stalled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                apply_table_op(i_command, i_key);
                ops_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (ops_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct()) begin
                    i_valid   <= 1'b1;
                    i_command <= ops_to_send[0].cmd;
                    i_key     <= ops_to_send[0].key;
                    void'(ops_to_send.pop_front());
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result against the oldest reply due.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                replies_seen++;
                if (replies_due.size() == 0) begin
                    report_mismatch($sformatf("result with nothing outstanding: st=%0d pos=%0d cnt=%0d",
                                              o_status, o_position, o_entry_count));
                end else begin
                    reply_want = replies_due.pop_front();
                    status_tally[o_status]++;
                    if (o_status !== reply_want.status)
                        report_mismatch($sformatf("result %0d status %0d, want %0d",
                                                  replies_seen, o_status, reply_want.status));
                    if (o_position !== reply_want.position)
                        report_mismatch($sformatf("result %0d position %0d, want %0d",
                                                  replies_seen, o_position, reply_want.position));
                    if (o_entry_count !== reply_want.count)
                        report_mismatch($sformatf("result %0d entry count %0d, want %0d",
                                                  replies_seen, o_entry_count, reply_want.count));
                end
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct());
        end
    end

    initial begin
        int   mode;
        int   run_len;
        int   roll;
        t_cmd cmd;

        // Directed: empty table, key extremes, duplicate, fill to full,
        // full and duplicate-while-full, then deletes at both ends and a miss.
        queue_op(CMD_SEARCH, 32'sd5);
        queue_op(CMD_DELETE, 32'sd5);
        queue_op(CMD_INSERT, 32'sh7FFF_FFFF);
        queue_op(CMD_INSERT, 32'sh8000_0000);
        queue_op(CMD_INSERT, 32'sd0);
        queue_op(CMD_INSERT, -32'sd1);
        queue_op(CMD_INSERT, 32'sh8000_0000);
        for (int i = 1; i <= CAPACITY - 4; i++)
            queue_op(CMD_INSERT, table_key_t'(1000 * i + 7 - 6000));
        queue_op(CMD_INSERT, 32'sd12345);
        queue_op(CMD_INSERT, -32'sd1);
        queue_op(CMD_SEARCH, 32'sh7FFF_FFFF);
        queue_op(CMD_DELETE, 32'sh8000_0000);
        queue_op(CMD_DELETE, 32'sh7FFF_FFFF);
        queue_op(CMD_DELETE, 32'sd12345);

        // Random: episodes that lean toward filling, draining or a mix.
        foreach (key_pool[i]) key_pool[i] = table_key_t'($urandom);
        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7FFF_FFFF;
        key_pool[2] = 32'sd0;
        key_pool[3] = -32'sd1;
        while (total_ops < RANDOM_OPS + 25) begin
            mode    = $urandom_range(2);
            run_len = $urandom_range(20, 40);
            key_pool[$urandom_range(4, POOL_SIZE - 1)] = table_key_t'($urandom);
            for (int n = 0; n < run_len; n++) begin
                roll = $urandom_range(99);
                case (mode)
                    0:       cmd = (roll < 70) ? CMD_INSERT : (roll < 85) ? CMD_SEARCH : CMD_DELETE;
                    1:       cmd = (roll < 60) ? CMD_DELETE : (roll < 80) ? CMD_INSERT : CMD_SEARCH;
                    default: cmd = (roll < 40) ? CMD_INSERT : (roll < 70) ? CMD_DELETE : CMD_SEARCH;
                endcase
                queue_op(cmd, pick_key());
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all items sent and accepted, all replies returned.
        @(negedge i_clk);
        while (ops_to_send.size() != 0 || i_valid || replies_due.size() != 0)
            @(negedge i_clk);
        repeat (5) @(posedge i_clk);
        if (replies_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", replies_due.size()));

        $display("Ran %0d table commands through four pacing phases, %0d results checked.",
                 ops_accepted, replies_seen);
        $display("Status mix: %0d done, %0d duplicate, %0d not found, %0d full.",
                 status_tally[ST_DONE], status_tally[ST_DUP],
                 status_tally[ST_MISS], status_tally[ST_FULL]);
        if (errors == 0) begin
            $display("sorted_unique_key_table test passed");
        end else begin
            $display("sorted_unique_key_table test failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("sorted_unique_key_table test failed");
        $finish;
    end

endmodule

// ----- sorted_unique_key_table.f -----
rtl/core/suk_pkg.sv
rtl/core/suk_cell.sv
rtl/core/sorted_unique_key_table.sv
bench/tb_sorted_unique_key_table.sv
